@@ hdl/dfbf_pkg.sv @@
// Shared types, constants and the BCD conversion step for the dial frequency frame unit.
`timescale 1ns / 1ps

package dfbf_pkg;

    localparam int FREQ_W    = 30;
    localparam int COUNT_W   = 16;
    localparam int STEP_W    = 10;
    localparam int PROD_W    = COUNT_W + STEP_W + 1;
    localparam int SUM_W     = 32;
    localparam int BIN_W     = 32;
    localparam int BCD_DIGITS = 9;
    localparam int BCD_W     = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int FRAME_DIGITS_W = 32;

    localparam logic [FREQ_W-1:0] FREQ_MAX   = 30'd999999999;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 30'd432750000;
    localparam logic [STEP_W-1:0] STEP_RESET = 10'd30;
    localparam logic [7:0]        FRAME_OPCODE = 8'h01;

    // Frame byte positions: four BCD bytes, then the opcode byte.
    localparam logic [2:0] BYTE_BCD0   = 3'd0;
    localparam logic [2:0] BYTE_BCD1   = 3'd1;
    localparam logic [2:0] BYTE_BCD2   = 3'd2;
    localparam logic [2:0] BYTE_BCD3   = 3'd3;
    localparam logic [2:0] BYTE_OPCODE = 3'd4;

    // Register indexes, taken from address bit 2.
    localparam logic REG_STEP_SIZE     = 1'b0;
    localparam logic REG_FOLLOW_ENABLE = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [COUNT_W-1:0]   encoder_count;
        logic [FREQ_W-1:0]    new_frequency;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_t;

    typedef struct packed {
        logic              valid;
        logic [FREQ_W-1:0] freq;
    } freq_push_t;

    // One shift-add-3 step: adjust every digit, then shift in the next binary bit.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

@@ hdl/dfbf_front.sv @@
// Request front end: encoder difference, step multiply, saturating frequency update.
`timescale 1ns / 1ps

module dfbf_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  dfbf_pkg::req_t                 req,
    input  logic [dfbf_pkg::STEP_W-1:0]    step_size,
    input  logic                           follow_enable,
    input  logic                           q_full,
    output dfbf_pkg::freq_push_t           push
);
    import dfbf_pkg::*;

    logic [COUNT_W-1:0]       prev_count_reg;
    logic [FREQ_W-1:0]        tuned_reg;
    logic                     pend_valid_reg;
    logic                     pend_load_reg;
    logic [FREQ_W-1:0]        pend_freq_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     accept;
    logic [COUNT_W-1:0]       diff;
    logic signed [PROD_W-1:0] prod_c;
    logic [FREQ_W-1:0]        load_sat;
    logic signed [SUM_W-1:0]  sum;
    logic [FREQ_W-1:0]        tuned_next;
    logic                     commit;

    assign req_ready = !pend_valid_reg;
    assign accept    = req_valid && req_ready;
    assign diff      = req.encoder_count - prev_count_reg;
    assign prod_c    = $signed(diff) * $signed({1'b0, step_size});
    assign load_sat  = (req.new_frequency > FREQ_MAX) ? FREQ_MAX : req.new_frequency;

    assign sum = $signed({{(SUM_W-FREQ_W){1'b0}}, tuned_reg})
               + $signed({{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    always_comb
    begin
        if (pend_load_reg)
        begin
            tuned_next = pend_freq_reg;
        end
        else if (sum < 0)
        begin
            tuned_next = '0;
        end
        else if (sum > $signed({{(SUM_W-FREQ_W){1'b0}}, FREQ_MAX}))
        begin
            tuned_next = FREQ_MAX;
        end
        else
        begin
            tuned_next = sum[FREQ_W-1:0];
        end
    end

    // The frequency is committed only when its frame has a queue slot.
    assign commit     = pend_valid_reg && !q_full;
    assign push.valid = commit;
    assign push.freq  = tuned_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            tuned_reg      <= FREQ_RESET;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                tuned_reg      <= tuned_next;
                pend_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (req.req_type)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else if (diff != '0)
                begin
                    prev_count_reg <= req.encoder_count;
                    pend_valid_reg <= follow_enable;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_load_reg <= req.req_type;
            pend_freq_reg <= load_sat;
            prod_reg      <= prod_c;
        end
    end

endmodule

@@ hdl/dfbf_queue.sv @@
// Two-entry frequency queue between the front end and the frame builder.
`timescale 1ns / 1ps

module dfbf_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dfbf_pkg::freq_push_t          push,
    output logic                          full,
    input  logic                          pop,
    output logic                          valid,
    output logic [dfbf_pkg::FREQ_W-1:0]   data
);
    import dfbf_pkg::*;

    logic [FREQ_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push.valid)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.freq;
        end
    end

endmodule

@@ hdl/dfbf_back.sv @@
// Frame builder: iterative binary to BCD conversion and five-byte frame output.
`timescale 1ns / 1ps

module dfbf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [dfbf_pkg::FREQ_W-1:0]   q_data,
    output logic                          q_pop,
    output logic                          frame_valid,
    input  logic                          frame_ready,
    output dfbf_pkg::frame_t              frame
);
    import dfbf_pkg::*;

    logic                      conv_busy_reg;
    logic                      conv_done_reg;
    logic [2:0]                conv_cnt_reg;
    logic [BIN_W-1:0]          conv_bin_reg;
    logic [BCD_W-1:0]          conv_bcd_reg;

    logic                      emit_active_reg;
    logic [2:0]                emit_idx_reg;
    logic [FRAME_DIGITS_W-1:0] digits_reg;
    logic                      out_valid_reg;
    frame_t                    out_reg;

    logic [BCD_W-1:0]          bcd_s1;
    logic [BCD_W-1:0]          bcd_s2;
    logic [BCD_W-1:0]          bcd_s3;
    logic [BCD_W-1:0]          bcd_s4;
    logic                      handoff;
    logic                      out_load;
    logic [7:0]                byte_sel;

    // Four conversion bits per cycle, most significant first.
    assign bcd_s1 = dd_step(conv_bcd_reg, conv_bin_reg[BIN_W-1]);
    assign bcd_s2 = dd_step(bcd_s1, conv_bin_reg[BIN_W-2]);
    assign bcd_s3 = dd_step(bcd_s2, conv_bin_reg[BIN_W-3]);
    assign bcd_s4 = dd_step(bcd_s3, conv_bin_reg[BIN_W-4]);

    assign handoff  = conv_done_reg && !emit_active_reg;
    assign q_pop    = q_valid && !conv_busy_reg && (!conv_done_reg || handoff);
    assign out_load = !out_valid_reg || frame_ready;

    always_comb
    begin
        case (emit_idx_reg)
            BYTE_BCD0: byte_sel = digits_reg[31:24];
            BYTE_BCD1: byte_sel = digits_reg[23:16];
            BYTE_BCD2: byte_sel = digits_reg[15:8];
            BYTE_BCD3: byte_sel = digits_reg[7:0];
            default:   byte_sel = FRAME_OPCODE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg   <= 1'b0;
            conv_done_reg   <= 1'b0;
            conv_cnt_reg    <= '0;
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= BYTE_BCD0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (conv_busy_reg)
            begin
                conv_cnt_reg <= conv_cnt_reg + 3'd1;
                if (conv_cnt_reg == 3'(CONV_STEPS - 1))
                begin
                    conv_busy_reg <= 1'b0;
                    conv_done_reg <= 1'b1;
                end
            end
            else if (q_pop)
            begin
                conv_busy_reg <= 1'b1;
                conv_done_reg <= 1'b0;
                conv_cnt_reg  <= '0;
            end
            else if (handoff)
            begin
                conv_done_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= emit_active_reg;
                if (emit_active_reg)
                begin
                    if (emit_idx_reg == BYTE_OPCODE)
                    begin
                        emit_active_reg <= 1'b0;
                    end
                    emit_idx_reg <= emit_idx_reg + 3'd1;
                end
            end

            if (handoff)
            begin
                emit_active_reg <= 1'b1;
                emit_idx_reg    <= BYTE_BCD0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_busy_reg)
        begin
            conv_bcd_reg <= bcd_s4;
            conv_bin_reg <= {conv_bin_reg[BIN_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
        end
        else if (q_pop)
        begin
            conv_bcd_reg <= '0;
            conv_bin_reg <= {{(BIN_W-FREQ_W){1'b0}}, q_data};
        end
        // The units digit of the Hz value is dropped to give 10 Hz units.
        if (handoff)
        begin
            digits_reg <= conv_bcd_reg[BCD_W-1:4];
        end
        if (out_load && emit_active_reg)
        begin
            out_reg.frame_byte <= byte_sel;
            out_reg.last_byte  <= (emit_idx_reg == BYTE_OPCODE);
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

endmodule

@@ hdl/dial_frequency_to_bcd_frame_unit.sv @@
// Top level of the dial frequency to packed-BCD frame unit.
//
//  Channel   Direction  Handshake                   Payload
//  req       in         req_valid / req_ready       dfbf_pkg::req_t
//  frame     out        frame_valid / frame_ready   dfbf_pkg::frame_t, one byte per transfer
//  config    in         APB psel/penable/pwrite     step_size at 0x0, follow_enable at 0x4
//
// The front end registers the difference and step multiply of a request, then
// performs the saturating add, which waits for a free queue slot; no request is taken
// while an update is pending. Each frame passes through the four-bit-per-cycle BCD
// converter and a handoff into the byte emitter; the five byte transfers overlap the
// next conversion. Reset restores the registers, the tuned frequency and the counter
// history; a stalled frame output backs up through the queue.
`timescale 1ns / 1ps

module dial_frequency_to_bcd_frame_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_ready,
    input  dfbf_pkg::req_t    req,
    output logic              frame_valid,
    input  logic              frame_ready,
    output dfbf_pkg::frame_t  frame
);
    import dfbf_pkg::*;

    logic [STEP_W-1:0] step_size_reg;
    logic              follow_enable_reg;
    logic              cfg_write;

    freq_push_t        push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [FREQ_W-1:0] q_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg     <= STEP_RESET;
            follow_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_STEP_SIZE:     step_size_reg     <= pwdata[STEP_W-1:0];
                REG_FOLLOW_ENABLE: follow_enable_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STEP_SIZE:     prdata = {{(32-STEP_W){1'b0}}, step_size_reg};
            REG_FOLLOW_ENABLE: prdata = {31'b0, follow_enable_reg};
            default:           prdata = '0;
        endcase
    end

    dfbf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .step_size     (step_size_reg),
        .follow_enable (follow_enable_reg),
        .q_full        (q_full),
        .push          (push)
    );

    dfbf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .data  (q_data)
    );

    dfbf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

endmodule

@@ bench/dial_frequency_frame_checker.sv @@
// Request kinds and the checker that predicts and compares the dial frame byte stream.
`timescale 1ns / 1ps

package dial_frame_tb_pkg;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

endpackage

module dial_frequency_frame_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              req_valid,
    input  logic              req_ready,
    input  dfbf_pkg::req_t    req,
    input  logic              frame_valid,
    input  logic              frame_ready,
    input  dfbf_pkg::frame_t  frame,
    output int                fail_count,
    output int                frames_outstanding
);

    import dfbf_pkg::*;
    import dial_frame_tb_pkg::*;

    logic [STEP_W-1:0]  step_hz;
    logic               follow_on;
    logic [FREQ_W-1:0]  dial_hz;
    logic [COUNT_W-1:0] last_count;
    frame_t             frame_bytes_due [$];

    // Eight BCD digits of the frequency in 10 Hz units, two per byte, then the opcode.
    function automatic void queue_bcd_frame(input logic [FREQ_W-1:0] hz);
        int unsigned tens;
        logic [3:0]  digit [8];
        frame_t      fb;
        tens = hz / 10;
        for (int i = 7; i >= 0; i--)
        begin
            digit[i] = 4'(tens % 10);
            tens = tens / 10;
        end
        for (int b = 0; b < 4; b++)
        begin
            fb.frame_byte = {digit[2*b], digit[2*b+1]};
            fb.last_byte  = 1'b0;
            frame_bytes_due.push_back(fb);
        end
        fb.frame_byte = FRAME_OPCODE;
        fb.last_byte  = 1'b1;
        frame_bytes_due.push_back(fb);
    endfunction

    function automatic void apply_request(input req_t r);
        logic signed [COUNT_W-1:0] delta;
        longint                    sum;
        if (r.req_type == REQ_LOAD)
        begin
            dial_hz = (r.new_frequency > FREQ_MAX) ? FREQ_MAX : r.new_frequency;
            queue_bcd_frame(dial_hz);
        end
        else
        begin
            // The count difference wraps at 16 bits and is read as signed.
            delta = r.encoder_count - last_count;
            if (delta != 0)
            begin
                last_count = r.encoder_count;
                if (follow_on)
                begin
                    sum = longint'(dial_hz) + longint'(step_hz) * longint'(delta);
                    if (sum < 0)
                    begin
                        sum = 0;
                    end
                    else if (sum > longint'(FREQ_MAX))
                    begin
                        sum = longint'(FREQ_MAX);
                    end
                    dial_hz = sum[FREQ_W-1:0];
                    queue_bcd_frame(dial_hz);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t due;
        if (!rst_n)
        begin
            step_hz            = STEP_RESET;
            follow_on          = 1'b1;
            dial_hz            = FREQ_RESET;
            last_count         = '0;
            frame_bytes_due.delete();
            fail_count         = 0;
            frames_outstanding = 0;
        end
        else
        begin
            if (frame_valid && frame_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame transfer with nothing expected: frame_byte %02h, last_byte %0b",
                           frame.frame_byte, frame.last_byte);
                    fail_count++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame.frame_byte !== due.frame_byte)
                    begin
                        $error("frame_byte: expected %02h, actual %02h",
                               due.frame_byte, frame.frame_byte);
                        fail_count++;
                    end
                    if (frame.last_byte !== due.last_byte)
                    begin
                        $error("last_byte: expected %0b, actual %0b",
                               due.last_byte, frame.last_byte);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_STEP_SIZE)
                begin
                    step_hz = pwdata[STEP_W-1:0];
                end
                else
                begin
                    follow_on = pwdata[0];
                end
            end
            if (req_valid && req_ready)
            begin
                apply_request(req);
            end
            frames_outstanding = frame_bytes_due.size();
        end
    end

endmodule

@@ bench/dial_frequency_to_bcd_frame_unit_test.sv @@
// Stimulus and verdict for the dial frequency to BCD frame unit.
`timescale 1ns / 1ps

module dial_frequency_to_bcd_frame_unit_test;

    import dfbf_pkg::*;
    import dial_frame_tb_pkg::*;

    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 60;
    localparam int HOLD_OFF_CYCLES = 300;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         req_valid;
    logic         req_ready;
    req_t         req;
    logic         frame_valid;
    logic         frame_ready;
    frame_t       frame;

    int           fail_count;
    int           frames_outstanding;
    int           cycle_count = 0;
    bit           tx_gaps_on  = 1'b1;
    bit           rx_gaps_on  = 1'b1;
    int           rx_hold_len = 0;
    logic [15:0]  count_cursor;

    always #4 clk = ~clk;

    dial_frequency_to_bcd_frame_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    dial_frequency_frame_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .req_valid          (req_valid),
        .req_ready          (req_ready),
        .req                (req),
        .frame_valid        (frame_valid),
        .frame_ready        (frame_ready),
        .frame              (frame),
        .fail_count         (fail_count),
        .frames_outstanding (frames_outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dial_frequency_to_bcd_frame_unit_test failed");
            $finish;
        end
    end

    // Frame receiver: short random stalls, or one long hold-off when asked for.
    initial
    begin
        frame_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                frame_ready = 1'b0;
                repeat (rx_hold_len - 1) @(negedge clk);
                rx_hold_len = 0;
            end
            else if (rx_gaps_on && $urandom_range(0, 4) == 0)
            begin
                frame_ready = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
            begin
                frame_ready = 1'b1;
            end
        end
    end

    task automatic stop_sending();
        req_valid = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input req_t r);
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (req_ready)
            begin
                break;
            end
        end
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [15:0] count);
        req_t r;
        r.req_type      = REQ_SAMPLE;
        r.encoder_count = count;
        r.new_frequency = 30'($urandom());
        send_req(r);
        count_cursor = count;
    endtask

    task automatic send_load(input logic [29:0] hz);
        req_t r;
        r.req_type      = REQ_LOAD;
        r.encoder_count = 16'($urandom());
        r.new_frequency = hz;
        send_req(r);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Registers change only once the unit has gone quiet.
    task automatic configure(input logic [31:0] step, input logic [31:0] follow);
        stop_sending();
        wait (frames_outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_STEP_SIZE, step);
        write_reg(REG_FOLLOW_ENABLE, follow);
    endtask

    task automatic random_item();
        logic [15:0] delta;
        int unsigned hz;
        if ($urandom_range(0, 99) < 18)
        begin
            case ($urandom_range(0, 9))
                0:       hz = $urandom_range(1000000000, 32'h3FFF_FFFF);
                1:       hz = $urandom_range(0, 200);
                2:       hz = 999999999 - $urandom_range(0, 200);
                default: hz = $urandom_range(0, 999999999);
            endcase
            send_load(hz[29:0]);
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:         delta = '0;
                1, 2:      delta = 16'($urandom());
                3, 4, 5:   delta = 16'($urandom_range(1, 2000));
                default:   delta = 16'($urandom_range(1, 64));
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                delta = -delta;
            end
            send_sample(count_cursor + delta);
        end
    endtask

    initial
    begin
        logic [31:0] step;
        logic [31:0] follow;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        req          = '0;
        count_cursor = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values: step 30, following on.
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h7FFE);
        send_sample(16'hFFFE);
        send_load(30'd0);
        send_sample(16'hFFFD);
        send_load(30'd999999999);
        send_sample(16'h0000);
        send_load(30'h3FFF_FFFF);
        send_load(30'd123456789);
        send_load(30'd9);

        // A zero step still sends a frame of the unchanged frequency.
        configure(32'd0, 32'd1);
        send_sample(16'h0005);

        configure(32'd1023, 32'd0);
        send_sample(16'h1234);
        send_sample(16'h1234);
        send_load(30'd500000000);

        configure(32'd1023, 32'd1);
        send_sample(16'h1334);
        send_sample(16'h9334);

        configure(32'd1000, 32'd1);
        send_sample(16'h9335);
        send_load(30'd999999990);
        send_sample(16'h933A);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       step = 32'd1;
                1:       step = 32'd1000;
                2:       step = $urandom_range(1, 1000);
                3:       step = 32'd512;
                4:       step = $urandom_range(2, 999);
                default: step = 32'd30;
            endcase
            follow = (phase == 2) ? 32'd0 : 32'd1;
            configure(step, follow);
            if (phase == RANDOM_PHASES - 1)
            begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // The long receiver stall backs frames up until requests are refused.
                if (phase == 1 && i == 10)
                begin
                    rx_hold_len = HOLD_OFF_CYCLES;
                end
                random_item();
            end
        end

        stop_sending();
        wait (frames_outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("dial_frequency_to_bcd_frame_unit_test passed");
        end
        else
        begin
            $display("dial_frequency_to_bcd_frame_unit_test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/dfbf_pkg.sv
hdl/dfbf_front.sv
hdl/dfbf_queue.sv
hdl/dfbf_back.sv
hdl/dial_frequency_to_bcd_frame_unit.sv
bench/dial_frequency_frame_checker.sv
bench/dial_frequency_to_bcd_frame_unit_test.sv
